/* hw/rtl/mode_change_dwell_qualifier_unit_assert.svh */
// Assertion macros shared by the dwell qualifier RTL.
`ifndef MODE_CHANGE_DWELL_QUALIFIER_UNIT_ASSERT_SVH
`define MODE_CHANGE_DWELL_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCDQ_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mcdq_pkg.sv */
// Types and constants of the mode change dwell qualifier.
package mcdq_pkg;

    // Mode code, carried as a plain 3-bit value (codes 5 to 7 pass through)
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_IDLE      = 3'd0;
    localparam mode_t MODE_SOFT      = 3'd1;
    localparam mode_t MODE_CRUISE    = 3'd2;
    localparam mode_t MODE_OVERDRIVE = 3'd3;
    localparam mode_t MODE_PROTECT   = 3'd4;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_SOFT_TO_CRUISE      = 3'd0;
    localparam cfg_index_t REG_CRUISE_TO_OVERDRIVE = 3'd1;
    localparam cfg_index_t REG_OVERDRIVE_TO_CRUISE = 3'd2;
    localparam cfg_index_t REG_PROTECT_TO_CRUISE   = 3'd3;
    localparam cfg_index_t REG_DEFAULT_GUARD       = 3'd4;

endpackage

/* hw/rtl/mcdq_in_if.sv */
// Input frame channel: valid/ready handshake with present and requested mode.
interface mcdq_in_if;
    import mcdq_pkg::*;

    logic  valid;
    logic  ready;
    mode_t current_mode;
    mode_t desired_mode;

    modport source (output valid, output current_mode, output desired_mode, input ready);
    modport sink   (input valid, input current_mode, input desired_mode, output ready);
endinterface

/* hw/rtl/mcdq_out_if.sv */
// Result channel: valid/ready handshake with granted mode and change flag.
interface mcdq_out_if;
    import mcdq_pkg::*;

    logic  valid;
    logic  ready;
    mode_t granted_mode;
    logic  mode_changed;

    modport source (output valid, output granted_mode, output mode_changed, input ready);
    modport sink   (input valid, input granted_mode, input mode_changed, output ready);
endinterface

/* hw/rtl/mode_change_dwell_qualifier_unit.sv */
// Mode change dwell qualifier: frame register, qualify logic and result register.
//
// Usage:
//   in_ch  carries one frame per beat: current_mode and desired_mode.
//   out_ch returns one beat per frame: granted_mode and mode_changed.
//   cfg_we/cfg_index/cfg_data write the five delay registers (0 soft to cruise,
//   1 cruise to overdrive, 2 overdrive to cruise, 3 protection to cruise,
//   4 default guard); an index beyond 4 is ignored. Write only while idle.
// Timing:
//   A frame is accepted into the frame register, qualified there against the
//   dwell counters and registered into the result register when it advances.
//   One frame per cycle is sustained while out_ch.ready stays high; the
//   counter update in the qualify stage is combinational.
// Reset:
//   Delays clear to zero, the last request to idle, both counters to zero,
//   and both stages empty.
// Stall:
//   While out_ch.ready is low the result beat holds; one more frame waits in
//   the frame register and in_ch.ready drops until the result is taken.
`include "mode_change_dwell_qualifier_unit_assert.svh"

module mode_change_dwell_qualifier_unit #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mcdq_in_if.sink                       in_ch,
    mcdq_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [mcdq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [DELAY_WIDTH-1:0]        cfg_data
);
    import mcdq_pkg::*;

    localparam int COUNT_WIDTH = DELAY_WIDTH + 1;

    typedef logic [DELAY_WIDTH-1:0] delay_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Delay registers
    delay_t soft_to_cruise_reg;
    delay_t cruise_to_overdrive_reg;
    delay_t overdrive_to_cruise_reg;
    delay_t protect_to_cruise_reg;
    delay_t default_guard_reg;

    // Dwell state
    mode_t  last_request_reg, last_request_next;
    count_t stable_count_reg, stable_count_next;
    count_t since_change_count_reg, since_change_count_next;

    // Frame register
    logic   s1_valid_reg;
    mode_t  s1_current_reg;
    mode_t  s1_desired_reg;

    // Result register
    logic   out_valid_reg;
    mode_t  out_granted_reg;
    logic   out_changed_reg;

    logic   s1_advance;
    count_t since_inc;
    count_t stable_base;
    count_t stable_inc;
    delay_t need;
    count_t need_ext;
    logic   qualified;
    mode_t  grant;
    logic   grant_change;

    // Handshake: the frame moves on when the result register is free or drains
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_advance;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.granted_mode = out_granted_reg;
    assign out_ch.mode_changed = out_changed_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_to_cruise_reg      <= '0;
            cruise_to_overdrive_reg <= '0;
            overdrive_to_cruise_reg <= '0;
            protect_to_cruise_reg   <= '0;
            default_guard_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOFT_TO_CRUISE:      soft_to_cruise_reg      <= cfg_data;
                REG_CRUISE_TO_OVERDRIVE: cruise_to_overdrive_reg <= cfg_data;
                REG_OVERDRIVE_TO_CRUISE: overdrive_to_cruise_reg <= cfg_data;
                REG_PROTECT_TO_CRUISE:   protect_to_cruise_reg   <= cfg_data;
                REG_DEFAULT_GUARD:       default_guard_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturating counter advance and request tracking
    always_comb
    begin
        since_inc   = (since_change_count_reg == '1) ? since_change_count_reg
                                                     : since_change_count_reg + 1'b1;
        stable_base = (s1_desired_reg != last_request_reg) ? '0 : stable_count_reg;
        stable_inc  = (stable_base == '1) ? stable_base : stable_base + 1'b1;
    end

    // Look up the required dwell for this transition
    always_comb
    begin
        if (s1_current_reg == s1_desired_reg || s1_desired_reg == MODE_PROTECT)
            need = '0;
        else if (s1_current_reg == MODE_SOFT && s1_desired_reg == MODE_CRUISE)
            need = soft_to_cruise_reg;
        else if (s1_current_reg == MODE_CRUISE && s1_desired_reg == MODE_OVERDRIVE)
            need = cruise_to_overdrive_reg;
        else if (s1_current_reg == MODE_OVERDRIVE && s1_desired_reg == MODE_CRUISE)
            need = overdrive_to_cruise_reg;
        else if (s1_current_reg == MODE_PROTECT && s1_desired_reg == MODE_CRUISE)
            need = protect_to_cruise_reg;
        else if ((s1_current_reg == MODE_IDLE && s1_desired_reg == MODE_SOFT)
              || (s1_current_reg == MODE_SOFT && s1_desired_reg == MODE_IDLE)
              || (s1_current_reg == MODE_CRUISE && s1_desired_reg == MODE_SOFT))
            need = '0;
        else
            need = default_guard_reg;
    end

    // Qualify the request and form next state
    always_comb
    begin
        need_ext     = {1'b0, need};
        qualified    = (stable_inc > need_ext) && (since_inc > need_ext);
        grant        = qualified ? s1_desired_reg : s1_current_reg;
        grant_change = (grant != s1_current_reg);

        last_request_next       = s1_desired_reg;
        stable_count_next       = stable_inc;
        since_change_count_next = grant_change ? '0 : since_inc;
    end

    // Advance dwell state once per frame that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_request_reg       <= MODE_IDLE;
            stable_count_reg       <= '0;
            since_change_count_reg <= '0;
        end
        else if (s1_advance)
        begin
            last_request_reg       <= last_request_next;
            stable_count_reg       <= stable_count_next;
            since_change_count_reg <= since_change_count_next;
        end
    end

    // Frame register: load on each accepted beat, drop when it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_current_reg <= in_ch.current_mode;
            s1_desired_reg <= in_ch.desired_mode;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_granted_reg <= grant;
            out_changed_reg <= grant_change;
        end
    end

    // Checks
    `MCDQ_ASSERT_NOW(a_counts_start_together, clk, rst_n,
        stable_count_reg == '0, since_change_count_reg == '0,
        "since-change count moved before any frame was qualified")
    `MCDQ_ASSERT_NEXT(a_new_request_restarts_dwell, clk, rst_n,
        s1_advance && (s1_desired_reg != last_request_reg),
        stable_count_reg == count_t'(1),
        "new request did not restart the stable count")
    `MCDQ_ASSERT_NEXT(a_change_clears_since, clk, rst_n,
        s1_advance && grant_change,
        out_changed_reg && since_change_count_reg == '0,
        "granted change did not clear the since-change count")
    `MCDQ_ASSERT_NEXT(a_stalled_frame_held, clk, rst_n,
        s1_valid_reg && !s1_advance,
        s1_valid_reg && out_valid_reg,
        "waiting frame lost while the result stage was full")

endmodule
